// ===== src/segment_pair_closest_points_assert.svh =====
// Assertion macros shared by the segment pair RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SEGMENT_PAIR_CLOSEST_POINTS_ASSERT_SVH
`define SEGMENT_PAIR_CLOSEST_POINTS_ASSERT_SVH

// Same-cycle implication.
`define SPCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment pair assertion failed");

// Next-cycle implication.
`define SPCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment pair assertion failed");

`endif

// ===== src/spcp_pkg.sv =====
// Types, widths and helper functions for the segment pair closest point block.
// Depends on nothing; used by the top level.
package spcp_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int DW         = COORD_BITS + 1;
  localparam int SW         = 2 * DW + 1;
  localparam int WW         = 2 * SW + 1;
  localparam int FW         = FRAC_BITS + 1;
  localparam int GW         = 2 * COORD_BITS + 3;
  localparam int NW         = DW + FW + 1;
  localparam int MUL_LAT    = 2;
  localparam int DIV_LAT    = FRAC_BITS + 2;
  localparam int PIPE_DEPTH = 2 + MUL_LAT + 1 + DIV_LAT + 2 + DIV_LAT + 2;

  localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    MODE_GENERAL,
    MODE_B_ZERO,
    MODE_A_ZERO,
    MODE_BOTH_ZERO
  } mode_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } in_t;

  typedef struct packed {
    logic        [FW-1:0]         a_fraction;
    logic        [FW-1:0]         b_fraction;
    logic signed [COORD_BITS-1:0] a_near_x;
    logic signed [COORD_BITS-1:0] a_near_y;
    logic signed [COORD_BITS-1:0] b_near_x;
    logic signed [COORD_BITS-1:0] b_near_y;
    logic        [GW-1:0]         gap_squared;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] asx;
    logic signed [COORD_BITS-1:0] asy;
    logic signed [COORD_BITS-1:0] bsx;
    logic signed [COORD_BITS-1:0] bsy;
    logic signed [DW-1:0]         d1x;
    logic signed [DW-1:0]         d1y;
    logic signed [DW-1:0]         d2x;
    logic signed [DW-1:0]         d2y;
  } geo_t;

  typedef struct packed {
    logic signed [SW-1:0] dd1;
    logic signed [SW-1:0] dd2;
    logic signed [SW-1:0] rd1;
    logic signed [SW-1:0] rd2;
    logic signed [SW-1:0] d12;
  } dot_t;

  typedef struct packed {
    geo_t  geo;
    dot_t  dot;
    mode_e mode;
  } side_t;

  typedef struct packed {
    geo_t          geo;
    logic          to_a;
    logic [FW-1:0] other;
  } tail_t;

  function automatic logic signed [SW-1:0] dot2(
    input logic signed [DW-1:0] ax,
    input logic signed [DW-1:0] ay,
    input logic signed [DW-1:0] bx,
    input logic signed [DW-1:0] by
  );
    logic signed [2*DW-1:0] px;
    logic signed [2*DW-1:0] py;
    px = ax * bx;
    py = ay * by;
    return SW'(px) + SW'(py);
  endfunction

  // Rounds half toward plus infinity; the arithmetic shift is a floor.
  function automatic logic signed [COORD_BITS-1:0] near_coord(
    input logic signed [COORD_BITS-1:0] start,
    input logic signed [DW-1:0]         delta,
    input logic        [FW-1:0]         f
  );
    logic signed [NW-1:0] t;
    t = delta * $signed({1'b0, f});
    t = t + $signed(NW'(1) << (FRAC_BITS - 1));
    return start + COORD_BITS'(t >>> FRAC_BITS);
  endfunction

endpackage

// ===== src/segment_pair_closest_points.sv =====
// Closest points between two 2D segments: a fully pipelined datapath.
// Input channel: in_valid_i / in_stall_o with one in_t beat holding both
// segments as signed Q12.12 endpoints. Output channel: out_valid_o /
// out_stall_i with one out_t beat holding the two Q1.16 fractions, the two
// near points and the unsigned Q27.24 squared gap.
// A beat is taken at every clock edge with valid high and stall low; one
// result beat comes out for each input beat, in order.
// The datapath has 45 register stages: 2 * (FRAC_BITS + 2) divider stages
// plus 9 others. Throughput is one beat per cycle while the result beat is
// not stalled; the two 18-stage dividers set the depth.
// When the result beat is stalled the whole pipeline holds, and in_stall_o
// is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the first input beat may follow at once.
// Depends on spcp_pkg, spcp_mul, spcp_div and the assertion macro header.
`include "segment_pair_closest_points_assert.svh"
module segment_pair_closest_points (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spcp_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spcp_pkg::out_t out_o
);
  import spcp_pkg::*;

  logic                  pipe_en;
  logic [PIPE_DEPTH-1:0] vld_q;

  geo_t                  geo1_d, geo1_q;
  side_t                 side2_q, side3_q, side4_q, side5_d, side5_q;
  logic signed [2*SW-1:0] p_dd, p_dsq, p_nu, p_nv;
  logic signed [WW-1:0]  num, den, n1_d, n1_q, d1_d, d1_q;
  logic [FW-1:0]         f1;
  side_t                 side_line_q [0:DIV_LAT-1];
  side_t                 sm_q;
  logic [FW-1:0]         fm_q;
  logic signed [SW+FW:0] pm;
  logic signed [WW-1:0]  m_d, m_q, lim_d, lim_q;
  logic signed [WW-1:0]  n2_d, n2_q, d2_d, d2_q;
  tail_t                 tail_d, tail_q;
  tail_t                 tail_line_q [0:DIV_LAT-1];
  logic [FW-1:0]         f2;
  logic [FW-1:0]         fa, fb;
  out_t                  near_d, near_q, res_d, res_q;
  logic signed [COORD_BITS:0]     gx, gy;
  logic signed [2*COORD_BITS+1:0] sx, sy;

  assign pipe_en    = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o = !pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  always_comb begin
    geo1_d.asx = in_i.a_start_x;
    geo1_d.asy = in_i.a_start_y;
    geo1_d.bsx = in_i.b_start_x;
    geo1_d.bsy = in_i.b_start_y;
    geo1_d.d1x = DW'(in_i.a_end_x) - DW'(in_i.a_start_x);
    geo1_d.d1y = DW'(in_i.a_end_y) - DW'(in_i.a_start_y);
    geo1_d.d2x = DW'(in_i.b_end_x) - DW'(in_i.b_start_x);
    geo1_d.d2y = DW'(in_i.b_end_y) - DW'(in_i.b_start_y);
  end

  // The offset r = a_start - b_start is rebuilt from the starts.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      geo1_q <= geo1_d;
      side2_q.geo     <= geo1_q;
      side2_q.mode    <= MODE_GENERAL;
      side2_q.dot.dd1 <= dot2(geo1_q.d1x, geo1_q.d1y, geo1_q.d1x, geo1_q.d1y);
      side2_q.dot.dd2 <= dot2(geo1_q.d2x, geo1_q.d2y, geo1_q.d2x, geo1_q.d2y);
      side2_q.dot.d12 <= dot2(geo1_q.d1x, geo1_q.d1y, geo1_q.d2x, geo1_q.d2y);
      side2_q.dot.rd1 <= dot2(DW'(geo1_q.asx) - DW'(geo1_q.bsx),
                              DW'(geo1_q.asy) - DW'(geo1_q.bsy),
                              geo1_q.d1x, geo1_q.d1y);
      side2_q.dot.rd2 <= dot2(DW'(geo1_q.asx) - DW'(geo1_q.bsx),
                              DW'(geo1_q.asy) - DW'(geo1_q.bsy),
                              geo1_q.d2x, geo1_q.d2y);
      side3_q <= side2_q;
      side4_q <= side3_q;
    end
  end

  spcp_mul #(.AW(SW), .BW(SW)) u_mul_dd (
    .clk_i, .en_i(pipe_en), .a_i(side2_q.dot.dd1), .b_i(side2_q.dot.dd2), .p_o(p_dd)
  );
  spcp_mul #(.AW(SW), .BW(SW)) u_mul_dsq (
    .clk_i, .en_i(pipe_en), .a_i(side2_q.dot.d12), .b_i(side2_q.dot.d12), .p_o(p_dsq)
  );
  spcp_mul #(.AW(SW), .BW(SW)) u_mul_nu (
    .clk_i, .en_i(pipe_en), .a_i(side2_q.dot.d12), .b_i(side2_q.dot.rd2), .p_o(p_nu)
  );
  spcp_mul #(.AW(SW), .BW(SW)) u_mul_nv (
    .clk_i, .en_i(pipe_en), .a_i(side2_q.dot.rd1), .b_i(side2_q.dot.dd2), .p_o(p_nv)
  );

  always_comb begin
    num     = WW'(p_nu) - WW'(p_nv);
    den     = WW'(p_dd) - WW'(p_dsq);
    side5_d = side4_q;
    n1_d    = '0;
    d1_d    = '0;
    if (side4_q.dot.dd1 == 0 && side4_q.dot.dd2 == 0) begin
      side5_d.mode = MODE_BOTH_ZERO;
    end else if (side4_q.dot.dd2 == 0) begin
      side5_d.mode = MODE_B_ZERO;
    end else if (side4_q.dot.dd1 == 0) begin
      side5_d.mode = MODE_A_ZERO;
    end else begin
      side5_d.mode = MODE_GENERAL;
      if (den != 0) begin
        n1_d = num;
        d1_d = den;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side5_q <= side5_d;
      n1_q    <= n1_d;
      d1_q    <= d1_d;
    end
  end

  spcp_div #(.WIDTH(WW), .FRAC(FRAC_BITS)) u_div_a (
    .clk_i, .en_i(pipe_en), .num_i(n1_q), .den_i(d1_q), .quo_o(f1)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_line_q[0] <= side5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_line_q[i] <= side_line_q[i-1];
      end
    end
  end

  always_comb begin
    pm    = side_line_q[DIV_LAT-1].dot.d12 * $signed({1'b0, f1});
    m_d   = WW'(pm) + (WW'(side_line_q[DIV_LAT-1].dot.rd2) <<< FRAC_BITS);
    lim_d = WW'(side_line_q[DIV_LAT-1].dot.dd2) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sm_q  <= side_line_q[DIV_LAT-1];
      fm_q  <= f1;
      m_q   <= m_d;
      lim_q <= lim_d;
    end
  end

  always_comb begin
    tail_d.geo   = sm_q.geo;
    tail_d.to_a  = 1'b1;
    tail_d.other = '0;
    n2_d         = '0;
    d2_d         = '0;
    case (sm_q.mode)
      MODE_BOTH_ZERO: begin
        tail_d.to_a = 1'b1;
      end
      MODE_B_ZERO: begin
        n2_d = -(WW'(sm_q.dot.rd1));
        d2_d = WW'(sm_q.dot.dd1);
      end
      MODE_A_ZERO: begin
        tail_d.to_a = 1'b0;
        n2_d        = WW'(sm_q.dot.rd2);
        d2_d        = WW'(sm_q.dot.dd2);
      end
      MODE_GENERAL: begin
        if (m_q[WW-1]) begin
          n2_d = -(WW'(sm_q.dot.rd1));
          d2_d = WW'(sm_q.dot.dd1);
        end else if (m_q > lim_q) begin
          tail_d.other = FRAC_ONE;
          n2_d         = WW'(sm_q.dot.d12) - WW'(sm_q.dot.rd1);
          d2_d         = WW'(sm_q.dot.dd1);
        end else begin
          tail_d.to_a  = 1'b0;
          tail_d.other = fm_q;
          n2_d         = m_q;
          d2_d         = lim_q;
        end
      end
      default: begin
        tail_d.to_a = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tail_q <= tail_d;
      n2_q   <= n2_d;
      d2_q   <= d2_d;
    end
  end

  spcp_div #(.WIDTH(WW), .FRAC(FRAC_BITS)) u_div_b (
    .clk_i, .en_i(pipe_en), .num_i(n2_q), .den_i(d2_q), .quo_o(f2)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tail_line_q[0] <= tail_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        tail_line_q[i] <= tail_line_q[i-1];
      end
    end
  end

  always_comb begin
    fa = tail_line_q[DIV_LAT-1].to_a ? f2 : tail_line_q[DIV_LAT-1].other;
    fb = tail_line_q[DIV_LAT-1].to_a ? tail_line_q[DIV_LAT-1].other : f2;
    near_d             = '0;
    near_d.a_fraction  = fa;
    near_d.b_fraction  = fb;
    near_d.a_near_x    = near_coord(tail_line_q[DIV_LAT-1].geo.asx,
                                    tail_line_q[DIV_LAT-1].geo.d1x, fa);
    near_d.a_near_y    = near_coord(tail_line_q[DIV_LAT-1].geo.asy,
                                    tail_line_q[DIV_LAT-1].geo.d1y, fa);
    near_d.b_near_x    = near_coord(tail_line_q[DIV_LAT-1].geo.bsx,
                                    tail_line_q[DIV_LAT-1].geo.d2x, fb);
    near_d.b_near_y    = near_coord(tail_line_q[DIV_LAT-1].geo.bsy,
                                    tail_line_q[DIV_LAT-1].geo.d2y, fb);
  end

  always_comb begin
    gx    = (COORD_BITS + 1)'(near_q.a_near_x) - (COORD_BITS + 1)'(near_q.b_near_x);
    gy    = (COORD_BITS + 1)'(near_q.a_near_y) - (COORD_BITS + 1)'(near_q.b_near_y);
    sx    = gx * gx;
    sy    = gy * gy;
    res_d = near_q;
    res_d.gap_squared = GW'($unsigned(sx)) + GW'($unsigned(sy));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      near_q <= near_d;
      res_q  <= res_d;
    end
  end

  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign out_o       = res_q;

  `SPCP_ASSERT_NOW(a_frac_a_range, out_valid_o, out_o.a_fraction <= FRAC_ONE)
  `SPCP_ASSERT_NOW(a_frac_b_range, out_valid_o, out_o.b_fraction <= FRAC_ONE)
  `SPCP_ASSERT_NEXT(a_hold_on_stall, !pipe_en, $stable(vld_q))
  `SPCP_ASSERT_NEXT(a_take_beat, in_valid_i && !in_stall_o, vld_q[0])

endmodule

// ===== src/spcp_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
// Depends on nothing; used by the segment pair top level.
module spcp_mul #(
  parameter int AW = 51,
  parameter int BW = 51
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH+BH-1:0] hh_d, hh_q;
  logic signed [AH+BL:0]   hl_d, hl_q;
  logic signed [AL+BH:0]   lh_d, lh_q;
  logic        [AL+BL-1:0] ll_d, ll_q;
  logic signed [PW-1:0]    p_d, p_q;

  always_comb begin
    hh_d = $signed(a_i[AW-1:AL]) * $signed(b_i[BW-1:BL]);
    hl_d = $signed(a_i[AW-1:AL]) * $signed({1'b0, b_i[BL-1:0]});
    lh_d = $signed({1'b0, a_i[AL-1:0]}) * $signed(b_i[BW-1:BL]);
    ll_d = a_i[AL-1:0] * b_i[BL-1:0];
    p_d  = (PW'(hh_q) <<< (AL + BL)) + (PW'(hl_q) <<< AL) + (PW'(lh_q) <<< BL)
         + $signed(PW'(ll_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      ll_q <= ll_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== src/spcp_div.sv =====
// Pipelined restoring divider giving num/den clamped to [0, 1] in fixed point,
// rounded half up, one quotient bit per stage. Depends on nothing.
module spcp_div #(
  parameter int WIDTH = 103,
  parameter int FRAC  = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WIDTH-1:0] num_i,
  input  logic signed [WIDTH-1:0] den_i,
  output logic        [FRAC:0]    quo_o
);

  localparam logic [FRAC:0] ONE = (FRAC + 1)'(1) << FRAC;

  logic [WIDTH-1:0] r_q    [0:FRAC];
  logic [WIDTH-1:0] d_q    [0:FRAC];
  logic [FRAC-1:0]  q_q    [0:FRAC];
  logic             zero_q [0:FRAC];
  logic             one_q  [0:FRAC];
  logic [FRAC:0]    quo_d, quo_q;
  logic [WIDTH-1:0] last_t;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= $unsigned(num_i);
      d_q[0]    <= $unsigned(den_i);
      q_q[0]    <= '0;
      zero_q[0] <= (den_i <= 0) || (num_i <= 0);
      one_q[0]  <= num_i >= den_i;
    end
  end

  for (genvar i = 1; i <= FRAC; i++) begin : g_bit
    logic [WIDTH-1:0] t;
    logic             take;
    always_comb begin
      t    = {r_q[i-1][WIDTH-2:0], 1'b0};
      take = t >= d_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i]    <= take ? t - d_q[i-1] : t;
        d_q[i]    <= d_q[i-1];
        q_q[i]    <= {q_q[i-1][FRAC-2:0], take};
        zero_q[i] <= zero_q[i-1];
        one_q[i]  <= one_q[i-1];
      end
    end
  end

  always_comb begin
    last_t = {r_q[FRAC][WIDTH-2:0], 1'b0};
    if (zero_q[FRAC]) begin
      quo_d = '0;
    end else if (one_q[FRAC]) begin
      quo_d = ONE;
    end else begin
      quo_d = {1'b0, q_q[FRAC]} + (FRAC + 1)'(last_t >= d_q[FRAC]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== bench/tb_segment_pair_closest_points.sv =====
// Self-checking bench for segment_pair_closest_points: directed segment pairs, then
// random ones, with random gaps and stalls on both channels. Results are checked
// against a built-in predictor. Depends on spcp_pkg and the RTL top level.
module tb_segment_pair_closest_points;
  import spcp_pkg::*;

  typedef logic signed [127:0] big_t;

  typedef struct packed {
    in_t  pts;
    logic known;
    out_t want;
  } row_t;

  localparam logic signed [COORD_BITS-1:0] CMAX = 24'sd8388607;
  localparam logic signed [COORD_BITS-1:0] CMIN = -24'sd8388607 - 24'sd1;
  localparam logic [GW-1:0] GAP_FAR = GW'(2 * 64'd16777215 * 64'd16777215);
  localparam int N_RANDOM = 1885;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  out_t pending_results[$];
  int error_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int sender_idle_pct = 13;
  int receiver_idle_pct = 52;

  row_t dir_rows[15] = '{
    '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1, '0},
    '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN}, 1'b1,
      '{17'd0, 17'd0, CMAX, CMAX, CMIN, CMIN, GAP_FAR}},
    '{'{24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd2048, 24'sd4096, 24'sd2048, 24'sd4096},
      1'b0, '0},
    '{'{24'sd1000, -24'sd3000, 24'sd1000, -24'sd3000, -24'sd8192, 24'sd0, 24'sd8192, 24'sd0},
      1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0, 24'sd4096, 24'sd4096, 24'sd12288, 24'sd4096},
      1'b0, '0},
    '{'{-24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096, -24'sd4096, 24'sd4096, 24'sd4096,
        -24'sd4096}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd8192, 24'sd4096, 24'sd8192, 24'sd12288},
      1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd4096, 24'sd0, 24'sd8192, -24'sd12288, 24'sd8192, -24'sd4096},
      1'b0, '0},
    '{'{CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX}, 1'b0, '0},
    '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX}, 1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd8192, 24'sd0, 24'sd8192, 24'sd4096, 24'sd0, 24'sd4096},
      1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd4096, 24'sd4096, 24'sd8192, 24'sd8192, 24'sd12288, 24'sd12288},
      1'b0, '0},
    '{'{24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd1}, 1'b0, '0},
    '{'{CMIN, 24'sd0, CMAX, 24'sd0, 24'sd0, CMAX, 24'sd0, CMAX}, 1'b0, '0},
    '{'{CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX}, 1'b0, '0}
  };

  segment_pair_closest_points i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #2 clk_i = ~clk_i;

  // Clamped ratio n/d in [0, 1] at 2^FRAC_BITS scale, rounded half up.
  function automatic longint clamped_ratio(big_t n, big_t d);
    if (d <= 0 || n <= 0) return 0;
    if (n >= d) return longint'(FRAC_ONE);
    return longint'(((n <<< (FRAC_BITS + 1)) + d) / (2 * d));
  endfunction

  function automatic longint point_on(longint start, longint delta, longint f);
    longint t;
    t = f * delta + (64'sd1 <<< (FRAC_BITS - 1));
    return start + (t >>> FRAC_BITS);
  endfunction

  function automatic out_t closest_points(in_t s);
    longint asx, asy, bsx, bsy, d1x, d1y, d2x, d2y, rx, ry;
    longint len1, len2, proj1, proj2, cross12, fa, fb, anx, any, bnx, bny, gx, gy;
    big_t den, m, lim;
    out_t r;
    asx = s.a_start_x; asy = s.a_start_y;
    bsx = s.b_start_x; bsy = s.b_start_y;
    d1x = longint'(s.a_end_x) - asx; d1y = longint'(s.a_end_y) - asy;
    d2x = longint'(s.b_end_x) - bsx; d2y = longint'(s.b_end_y) - bsy;
    rx = asx - bsx; ry = asy - bsy;
    len1 = d1x * d1x + d1y * d1y;
    len2 = d2x * d2x + d2y * d2y;
    proj1 = rx * d1x + ry * d1y;
    proj2 = rx * d2x + ry * d2y;
    cross12 = d1x * d2x + d1y * d2y;
    fa = 0;
    fb = 0;
    if (len1 == 0 || len2 == 0) begin
      if (len1 != 0) fa = clamped_ratio(-big_t'(proj1), big_t'(len1));
      else if (len2 != 0) fb = clamped_ratio(big_t'(proj2), big_t'(len2));
    end else begin
      den = big_t'(len1) * big_t'(len2) - big_t'(cross12) * big_t'(cross12);
      if (den != 0)
        fa = clamped_ratio(big_t'(cross12) * big_t'(proj2) - big_t'(proj1) * big_t'(len2),
                           den);
      m = big_t'(cross12) * big_t'(fa) + (big_t'(proj2) <<< FRAC_BITS);
      lim = big_t'(len2) <<< FRAC_BITS;
      if (m < 0) begin
        fb = 0;
        fa = clamped_ratio(-big_t'(proj1), big_t'(len1));
      end else if (m > lim) begin
        fb = longint'(FRAC_ONE);
        fa = clamped_ratio(big_t'(cross12 - proj1), big_t'(len1));
      end else begin
        fb = clamped_ratio(m, lim);
      end
    end
    anx = point_on(asx, d1x, fa);
    any = point_on(asy, d1y, fa);
    bnx = point_on(bsx, d2x, fb);
    bny = point_on(bsy, d2y, fb);
    gx = anx - bnx;
    gy = any - bny;
    r.a_fraction = FW'(fa);
    r.b_fraction = FW'(fb);
    r.a_near_x = COORD_BITS'(anx);
    r.a_near_y = COORD_BITS'(any);
    r.b_near_x = COORD_BITS'(bnx);
    r.b_near_y = COORD_BITS'(bny);
    r.gap_squared = GW'(gx * gx + gy * gy);
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_value(int span);
    return COORD_BITS'($urandom_range(2 * span) - span);
  endfunction

  function automatic in_t random_pair();
    in_t s;
    int span;
    int kind;
    s = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    kind = $urandom_range(9);
    if (kind >= 3) begin
      span = ($urandom_range(3) == 0) ? 4194304 : 16384;
      s.a_start_x = near_value(span); s.a_start_y = near_value(span);
      s.a_end_x = near_value(span); s.a_end_y = near_value(span);
      s.b_start_x = near_value(span); s.b_start_y = near_value(span);
      s.b_end_x = near_value(span); s.b_end_y = near_value(span);
    end
    case (kind)
      4: begin
        s.a_end_x = s.a_start_x;
        s.a_end_y = s.a_start_y;
      end
      5: begin
        s.b_end_x = s.b_start_x;
        s.b_end_y = s.b_start_y;
      end
      6: begin
        s.a_end_x = s.a_start_x;
        s.a_end_y = s.a_start_y;
        s.b_end_x = s.b_start_x;
        s.b_end_y = s.b_start_y;
      end
      7: begin
        s.b_end_x = s.b_start_x + (s.a_end_x - s.a_start_x);
        s.b_end_y = s.b_start_y + (s.a_end_y - s.a_start_y);
      end
      8: begin
        s.b_end_x = s.b_start_x - (s.a_end_x - s.a_start_x);
        s.b_end_y = s.b_start_y - (s.a_end_y - s.a_start_y);
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_beat(in_t s, out_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= s;
    pending_results.push_back(want);
    beats_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending expectation");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        check_field("a_fraction", 64'(want.a_fraction), 64'(out_o.a_fraction));
        check_field("b_fraction", 64'(want.b_fraction), 64'(out_o.b_fraction));
        check_field("a_near_x", 64'(want.a_near_x), 64'(out_o.a_near_x));
        check_field("a_near_y", 64'(want.a_near_y), 64'(out_o.a_near_y));
        check_field("b_near_x", 64'(want.b_near_x), 64'(out_o.b_near_x));
        check_field("b_near_y", 64'(want.b_near_y), 64'(out_o.b_near_y));
        check_field("gap_squared", 64'(want.gap_squared), 64'(out_o.gap_squared));
      end
    end
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_t s;
    int waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[k]) begin
      s = dir_rows[k].pts;
      send_beat(s, dir_rows[k].known ? dir_rows[k].want : closest_points(s));
    end
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 52 : 0;
      receiver_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 13 : 0;
      for (int k = 0; k < N_RANDOM / 3; k++) begin
        s = random_pair();
        send_beat(s, closest_points(s));
      end
    end
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    $display("Sent %0d segment pairs, %0d checked, including degenerate and parallel cases.",
             beats_sent, beats_checked);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/spcp_pkg.sv
src/spcp_mul.sv
src/spcp_div.sv
src/segment_pair_closest_points.sv
bench/tb_segment_pair_closest_points.sv
